// ----- rtl/core/bbrs_pkg.sv -----
package bbrs_pkg;

	// Window geometry
	localparam int MAX_RADIUS = 31;
	localparam int RAD_W      = 5;
	localparam int SPAN_W     = RAD_W + 1;
	localparam int POS_W      = 6;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(2 * MAX_RADIUS + 1);
	localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 2;
	localparam int WIN_AW     = $clog2(WIN_DEPTH);

	// Running sums and fixed-point reciprocal of the window span
	localparam int SUM_W      = 14;
	localparam int RECIP_SH   = 20;
	localparam int RECIP_W    = RECIP_SH + 1;
	localparam int QUO_CNT_W  = $clog2(RECIP_SH);

	// Queue between front and back
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// Register port
	localparam int CFG_ADDR_W     = 3;
	localparam int REG_IDX_RADIUS = 0;
	localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(1);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		pixel_t               px;
		logic                 last;
		logic                 first;
		logic [POS_W-1:0]     pos;
		logic [RAD_W-1:0]     radius;
		logic [RECIP_W-1:0]   recip;
	} item_t;

	typedef struct packed {
		logic                 busy;
		logic [RAD_W-1:0]     radius;
		logic [RECIP_W-1:0]   recip;
	} cfg_t;

endpackage

// ----- rtl/core/bbrs_pixel_if.sv -----
interface bbrs_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	logic       line_last;

	modport source (output valid, red_in, green_in, blue_in, line_last, input ready);
	modport sink (input valid, red_in, green_in, blue_in, line_last, output ready);
endinterface

// ----- rtl/core/bbrs_blur_if.sv -----
interface bbrs_blur_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       line_end;
	logic       run_last;

	modport source (output valid, red_out, green_out, blue_out, line_end, run_last,
		input ready);
	modport sink (input valid, red_out, green_out, blue_out, line_end, run_last,
		output ready);
endinterface

// ----- rtl/core/box_blur_running_sum.sv -----
// One-dimensional box filter with edge clamp over an RGB pixel stream.
// Pixels enter on the pixel channel in line order, line_last on the final
// pixel of each row or column. Averaged pixels leave on the blurred channel;
// line_end marks the last filtered pixel of a line, run_last the last result
// caused by one input pixel. Each transfer is a cycle with valid and ready high.
// Radius is set over the register port (byte address 0) and takes effect at the
// first pixel of the next line.
// Throughput: one pixel per cycle while the back end is neither stalled nor
// flushing; a line_last pixel takes radius+1 slide steps in the back end, one per
// flushed output. The single window memory port and running-sum stage set that:
// one slide step per cycle while the output register can move. The pixel that
// completes a window passes from the input queue through stage s1, the running
// sums and s2 before its result reaches the output register. After reset the
// radius is 1 and pixel.ready stays low while the reciprocal of the span is
// formed one bit a cycle; every radius write holds pixel.ready low the same way.
// When the receiver stalls, the output register holds its result and the whole
// back end freezes; a four-entry queue takes further pixels, then ready drops.
module box_blur_running_sum (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bbrs_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	bbrs_pixel_if.sink                       pixel,
	bbrs_blur_if.source                      blurred
);
	bbrs_pkg::cfg_t  cfg;
	bbrs_pkg::item_t item;
	bbrs_pkg::item_t head;
	logic            push;
	logic            full;
	logic            pop;
	logic            empty;

	// Radius register and span reciprocal
	bbrs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Front: take pixels, track line position, latch radius per line
	bbrs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel),
		.cfg    (cfg),
		.full   (full),
		.push   (push),
		.item   (item)
	);

	// Decouple the front from the flush steps of the back
	bbrs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (item),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.head   (head)
	);

	// Back: window memory, running sums, divide by span, output register
	bbrs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.head    (head),
		.pop     (pop),
		.blurred (blurred)
	);
endmodule

// ----- rtl/core/bbrs_cfg.sv -----
module bbrs_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bbrs_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	output bbrs_pkg::cfg_t                      cfg
);
	localparam int IDX_W = bbrs_pkg::CFG_ADDR_W - 2;

	logic                              hit;
	logic                              wr;
	logic [bbrs_pkg::RAD_W-1:0]        wr_radius;
	logic [bbrs_pkg::RAD_W-1:0]        radius_q;
	logic                              busy_q;
	logic [bbrs_pkg::QUO_CNT_W-1:0]    cnt_q;
	logic [bbrs_pkg::SPAN_W-1:0]       rem_q;
	logic [bbrs_pkg::RECIP_SH-1:0]     quo_q;
	logic [bbrs_pkg::RECIP_SH-1:0]     quo_nx;
	logic [bbrs_pkg::RECIP_W-1:0]      recip_q;
	logic [bbrs_pkg::SPAN_W-1:0]       span;
	logic [bbrs_pkg::SPAN_W:0]         rem_sh;
	logic [bbrs_pkg::SPAN_W:0]         rem_sub;
	logic                              take;

	assign hit = paddr[bbrs_pkg::CFG_ADDR_W-1:2] == IDX_W'(bbrs_pkg::REG_IDX_RADIUS);
	assign wr  = psel && penable && pwrite && hit;
	assign wr_radius = (pwdata[bbrs_pkg::RAD_W-1:0] > bbrs_pkg::RAD_W'(bbrs_pkg::MAX_RADIUS))
		? bbrs_pkg::RAD_W'(bbrs_pkg::MAX_RADIUS) : pwdata[bbrs_pkg::RAD_W-1:0];

	// Restoring division of an all-ones numerator, one quotient bit per cycle:
	// recip = floor((2^20 - 1) / span) + 1 = ceil(2^20 / span)
	assign span    = {radius_q, 1'b1};
	assign rem_sh  = {rem_q, 1'b1};
	assign take    = rem_sh >= {1'b0, span};
	assign rem_sub = rem_sh - {1'b0, span};
	assign quo_nx  = {quo_q[bbrs_pkg::RECIP_SH-2:0], take};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= bbrs_pkg::RADIUS_RST;
			busy_q   <= 1'b1;
			cnt_q    <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			recip_q  <= '0;
		end else if (wr) begin
			radius_q <= wr_radius;
			busy_q   <= 1'b1;
			cnt_q    <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
		end else if (busy_q) begin
			rem_q <= take ? rem_sub[bbrs_pkg::SPAN_W-1:0] : rem_sh[bbrs_pkg::SPAN_W-1:0];
			quo_q <= quo_nx;
			cnt_q <= cnt_q + bbrs_pkg::QUO_CNT_W'(1);
			if (cnt_q == bbrs_pkg::QUO_CNT_W'(bbrs_pkg::RECIP_SH - 1)) begin
				busy_q  <= 1'b0;
				recip_q <= {1'b0, quo_nx} + bbrs_pkg::RECIP_W'(1);
			end
		end
	end

	assign prdata = hit ? 32'(radius_q) : 32'd0;
	assign pready = 1'b1;
	assign cfg    = '{busy: busy_q, radius: radius_q, recip: recip_q};
endmodule

// ----- rtl/core/bbrs_front.sv -----
module bbrs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	bbrs_pixel_if.sink           pixel,
	input  bbrs_pkg::cfg_t       cfg,
	input  logic                 full,
	output logic                 push,
	output bbrs_pkg::item_t      item
);
	logic [bbrs_pkg::POS_W-1:0]   pos_q;
	logic [bbrs_pkg::RAD_W-1:0]   radius_q;
	logic [bbrs_pkg::RECIP_W-1:0] recip_q;
	logic                         first;

	assign pixel.ready = !full && !cfg.busy;
	assign push        = pixel.valid && pixel.ready;
	assign first       = pos_q == '0;

	// Radius and reciprocal latch at the first pixel of a line
	assign item.px     = '{red: pixel.red_in, green: pixel.green_in, blue: pixel.blue_in};
	assign item.last   = pixel.line_last;
	assign item.first  = first;
	assign item.pos    = pos_q;
	assign item.radius = first ? cfg.radius : radius_q;
	assign item.recip  = first ? cfg.recip : recip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			radius_q <= '0;
			recip_q  <= '0;
		end else if (push) begin
			if (first) begin
				radius_q <= cfg.radius;
				recip_q  <= cfg.recip;
			end
			if (pixel.line_last) begin
				pos_q <= '0;
			end else if (pos_q != bbrs_pkg::POS_MAX) begin
				pos_q <= pos_q + bbrs_pkg::POS_W'(1);
			end
		end
	end
endmodule

// ----- rtl/core/bbrs_fifo.sv -----
module bbrs_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  bbrs_pkg::item_t      din,
	output logic                 full,
	input  logic                 pop,
	output logic                 empty,
	output bbrs_pkg::item_t      head
);
	bbrs_pkg::item_t                 slot_q [bbrs_pkg::FIFO_DEPTH];
	logic [bbrs_pkg::FIFO_AW-1:0]    wr_q;
	logic [bbrs_pkg::FIFO_AW-1:0]    rd_q;
	logic [bbrs_pkg::FIFO_AW:0]      cnt_q;

	assign full  = cnt_q == (bbrs_pkg::FIFO_AW + 1)'(bbrs_pkg::FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + bbrs_pkg::FIFO_AW'(1);
			if (pop) rd_q <= rd_q + bbrs_pkg::FIFO_AW'(1);
			cnt_q <= cnt_q + (bbrs_pkg::FIFO_AW + 1)'(push) - (bbrs_pkg::FIFO_AW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= din;
	end
endmodule

// ----- rtl/core/bbrs_back.sv -----
module bbrs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  bbrs_pkg::item_t      head,
	output logic                 pop,
	bbrs_blur_if.source          blurred
);
	typedef struct packed {
		logic                                valid;
		logic                                first;
		logic                                use_mem;
		logic                                emit;
		logic                                line_end;
		logic                                run_last;
		bbrs_pkg::pixel_t                    px;
		logic [bbrs_pkg::SPAN_W-1:0]         span;
		logic [bbrs_pkg::RECIP_W-1:0]        recip;
	} step_t;

	typedef struct packed {
		logic                                valid;
		logic                                line_end;
		logic                                run_last;
		logic [bbrs_pkg::RECIP_W-1:0]        recip;
	} mult_t;

	localparam int EXT_W  = bbrs_pkg::POS_W + 1;
	localparam int PROD_W = bbrs_pkg::SUM_W + bbrs_pkg::RECIP_W;

	bbrs_pkg::pixel_t                 win_mem [bbrs_pkg::WIN_DEPTH];
	bbrs_pkg::pixel_t                 rd_s1;
	step_t                            nx;
	step_t                            s1;
	mult_t                            s2;
	logic [bbrs_pkg::RAD_W-1:0]       step_q;
	logic [bbrs_pkg::WIN_AW-1:0]      wp_q;
	logic [bbrs_pkg::WIN_AW-1:0]      rd_addr;
	logic [bbrs_pkg::SPAN_W-1:0]      span;
	logic [EXT_W-1:0]                 pos_ext;
	logic                             adv;
	logic                             issue;
	logic                             final_step;
	logic [bbrs_pkg::SUM_W-1:0]       sum_q [3];
	bbrs_pkg::pixel_t                 first_q;
	bbrs_pkg::pixel_t                 drop;
	logic                             out_valid_q;
	bbrs_pkg::pixel_t                 out_px_q;
	logic                             out_end_q;
	logic                             out_last_q;

	function automatic logic [bbrs_pkg::SUM_W-1:0] slide(logic [bbrs_pkg::SUM_W-1:0] s,
		logic [7:0] add, logic [7:0] sub);
		return s + bbrs_pkg::SUM_W'(add) - bbrs_pkg::SUM_W'(sub);
	endfunction

	function automatic logic [bbrs_pkg::SUM_W-1:0] seed(logic [bbrs_pkg::SPAN_W-1:0] n,
		logic [7:0] v);
		return bbrs_pkg::SUM_W'(n) * bbrs_pkg::SUM_W'(v);
	endfunction

	// floor(s / span) as (s * ceil(2^20 / span)) >> 20, exact for 14-bit sums
	function automatic logic [7:0] mean(logic [bbrs_pkg::SUM_W-1:0] s,
		logic [bbrs_pkg::RECIP_W-1:0] r);
		logic [PROD_W-1:0] p;
		p = PROD_W'(s) * PROD_W'(r);
		return p[bbrs_pkg::RECIP_SH +: 8];
	endfunction

	// Whole pipeline advances together while the output register can move
	assign adv        = !out_valid_q || blurred.ready;
	assign issue      = adv && !empty;
	assign final_step = step_q == (head.last ? head.radius : '0);
	assign pop        = issue && final_step;

	// Step s of an item slides in the pixel again (s = 0 is the pixel itself,
	// s > 0 are the clamped positions past the line end) and drops the entry
	// span - s behind the current write slot.
	assign span    = {head.radius, 1'b1};
	assign pos_ext = {1'b0, head.pos} + EXT_W'(step_q);
	assign rd_addr = wp_q - bbrs_pkg::WIN_AW'(span) + bbrs_pkg::WIN_AW'(step_q);

	assign nx.valid    = !empty;
	assign nx.first    = head.first && (step_q == '0);
	assign nx.use_mem  = pos_ext >= EXT_W'(span);
	assign nx.emit     = pos_ext >= EXT_W'(head.radius);
	assign nx.line_end = head.last && final_step;
	assign nx.run_last = final_step;
	assign nx.px       = head.px;
	assign nx.span     = span;
	assign nx.recip    = head.recip;

	assign drop = s1.use_mem ? rd_s1 : first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			wp_q        <= '0;
			s1          <= '0;
			s2          <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			s1          <= nx;
			s2          <= '{valid: s1.valid && s1.emit, line_end: s1.line_end,
				run_last: s1.run_last, recip: s1.recip};
			out_valid_q <= s2.valid;
			if (!empty) begin
				if (final_step) begin
					step_q <= '0;
					wp_q   <= wp_q + bbrs_pkg::WIN_AW'(1);
				end else begin
					step_q <= step_q + bbrs_pkg::RAD_W'(1);
				end
			end
		end
	end

	// Pixel window: at most one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (issue && step_q == '0) win_mem[wp_q] <= head.px;
		if (adv) rd_s1 <= win_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (adv && s1.valid) begin
			if (s1.first) begin
				first_q  <= s1.px;
				sum_q[0] <= seed(s1.span, s1.px.red);
				sum_q[1] <= seed(s1.span, s1.px.green);
				sum_q[2] <= seed(s1.span, s1.px.blue);
			end else begin
				sum_q[0] <= slide(sum_q[0], s1.px.red, drop.red);
				sum_q[1] <= slide(sum_q[1], s1.px.green, drop.green);
				sum_q[2] <= slide(sum_q[2], s1.px.blue, drop.blue);
			end
		end
		if (adv) begin
			out_px_q   <= '{red: mean(sum_q[0], s2.recip), green: mean(sum_q[1], s2.recip),
				blue: mean(sum_q[2], s2.recip)};
			out_end_q  <= s2.line_end;
			out_last_q <= s2.run_last;
		end
	end

	assign blurred.valid     = out_valid_q;
	assign blurred.red_out   = out_px_q.red;
	assign blurred.green_out = out_px_q.green;
	assign blurred.blue_out  = out_px_q.blue;
	assign blurred.line_end  = out_end_q;
	assign blurred.run_last  = out_last_q;
endmodule

// ----- verif/box_blur_running_sum_tb.sv -----
`timescale 1ns / 100ps

module box_blur_running_sum_tb;

	// Register map: one radius register, plus an unused slot past it
	localparam int REG_IDX_SPARE = bbrs_pkg::REG_IDX_RADIUS + 1;
	localparam logic [bbrs_pkg::CFG_ADDR_W-1:0] ADDR_RADIUS =
		bbrs_pkg::CFG_ADDR_W'(4 * bbrs_pkg::REG_IDX_RADIUS);
	localparam logic [bbrs_pkg::CFG_ADDR_W-1:0] ADDR_SPARE  =
		bbrs_pkg::CFG_ADDR_W'(4 * REG_IDX_SPARE);

	// Quiet cycles after the last result: pipeline depth plus the input queue
	localparam int DRAIN_PAD   = 12;
	// Worst case is every pixel flushing 32 results through the HOLD-mode stalls
	localparam int CYCLE_LIMIT = 500_000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 20;

	typedef struct packed {
		bbrs_pkg::pixel_t px;
		logic             line_end;
		logic             run_last;
	} blur_px_t;

	typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_COMB, SINK_HOLD} sink_mode_t;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [bbrs_pkg::CFG_ADDR_W-1:0] paddr;
	logic [31:0]                     pwdata;
	logic [31:0]                     prdata;
	logic                            pready;

	bbrs_pixel_if pixel_bus ();
	bbrs_blur_if  blur_bus ();

	box_blur_running_sum i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pixel   (pixel_bus),
		.blurred (blur_bus)
	);

	// Filter state as the block should hold it
	bbrs_pkg::pixel_t pix_hist [bbrs_pkg::WIN_DEPTH];
	int unsigned      chan_sum [3];
	bbrs_pkg::pixel_t line_head;
	int unsigned      line_pos;
	int unsigned      line_radius;
	int unsigned      radius_reg;

	// Averaged pixels owed by the block, oldest first
	blur_px_t blur_due [$];

	int          mismatches;
	int          pixels_sent;
	int          results_seen;
	int          lines_done;
	int          longest_line;
	logic [31:0] radius_seen;
	int unsigned cycle_count;
	int          burst_left;
	bit          pixel_held;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("box_blur_running_sum_tb: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	function automatic int unsigned chan_of(bbrs_pkg::pixel_t px, int c);
		case (c)
			0:       return px.red;
			1:       return px.green;
			default: return px.blue;
		endcase
	endfunction

	// Add the pixel entering the window and remove the one leaving it
	function automatic void slide_sums(bbrs_pkg::pixel_t add_px, bbrs_pkg::pixel_t drop_px);
		for (int c = 0; c < 3; c++) begin
			chan_sum[c] = chan_sum[c] + chan_of(add_px, c) - chan_of(drop_px, c);
		end
	endfunction

	function automatic blur_px_t window_mean(int unsigned span);
		blur_px_t b;
		b = '0;
		b.px.red   = 8'(chan_sum[0] / span);
		b.px.green = 8'(chan_sum[1] / span);
		b.px.blue  = 8'(chan_sum[2] / span);
		return b;
	endfunction

	// Work out every averaged pixel that one input pixel releases
	task automatic box_average_pixel(input bbrs_pkg::pixel_t px, input bit last);
		int unsigned      n;
		int unsigned      r;
		int unsigned      span;
		int unsigned      m;
		bbrs_pkg::pixel_t drop;
		blur_px_t         run [$];
		n = line_pos;
		if (n == 0) begin
			// First pixel of a line: latch the radius, prime the window by clamping left
			line_radius = radius_reg;
			line_head   = px;
			radius_seen[line_radius] = 1'b1;
			for (int c = 0; c < 3; c++) begin
				chan_sum[c] = (2 * line_radius + 1) * chan_of(px, c);
			end
		end else begin
			drop = (n >= 2 * line_radius + 1) ? pix_hist[2 * line_radius] : line_head;
			slide_sums(px, drop);
		end
		r    = line_radius;
		span = 2 * r + 1;
		for (int i = bbrs_pkg::WIN_DEPTH - 1; i > 0; i--) pix_hist[i] = pix_hist[i - 1];
		pix_hist[0] = px;

		if (n >= r) run.insert(run.size(), window_mean(span));

		if (last) begin
			// Flush: keep adding the last pixel as the right-hand clamp
			for (int s = 1; s <= r; s++) begin
				m    = n + s;
				drop = (m >= span) ? pix_hist[span - s] : line_head;
				slide_sums(px, drop);
				if (m >= r) run.insert(run.size(), window_mean(span));
			end
			if (run.size() > 0) run[run.size() - 1].line_end = 1'b1;
			line_pos = 0;
		end else begin
			line_pos = (n + 1 > bbrs_pkg::WIN_DEPTH - 1) ? bbrs_pkg::WIN_DEPTH - 1 : n + 1;
		end

		if (run.size() > 0) run[run.size() - 1].run_last = 1'b1;
		foreach (run[i]) blur_due.insert(blur_due.size(), run[i]);
	endtask

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Compare every blurred transfer against the oldest pending prediction
	always @(posedge clk) begin : check_blur
		blur_px_t want;
		if (blur_bus.valid === 1'b1 && blur_bus.ready === 1'b1) begin
			results_seen++;
			if (blur_due.size() == 0) begin
				$error("blurred transfer with no result due: rgb %h %h %h",
					blur_bus.red_out, blur_bus.green_out, blur_bus.blue_out);
				mismatches++;
			end else begin
				want = blur_due.pop_front();
				check_field("red_out",   want.px.red,   blur_bus.red_out);
				check_field("green_out", want.px.green, blur_bus.green_out);
				check_field("blue_out",  want.px.blue,  blur_bus.blue_out);
				check_field("line_end",  8'(want.line_end), 8'(blur_bus.line_end));
				check_field("run_last",  8'(want.run_last), 8'(blur_bus.run_last));
			end
		end
	end

	// Receiver back-pressure: a randomly picked open, random, comb or hold pattern; HOLD alternates stalls with open runs
	always @(posedge clk) begin : sink_stall
		int unsigned sink_tick;
		sink_mode_t  sink_mode;
		if (sink_tick % 64 == 0) sink_mode = sink_mode_t'($urandom_range(0, 3));
		case (sink_mode)
			SINK_OPEN:   blur_bus.ready <= 1'b1;
			SINK_RANDOM: blur_bus.ready <= ($urandom_range(0, 3) != 0);
			SINK_COMB:   blur_bus.ready <= (sink_tick % 7) >= 2;
			default:     blur_bus.ready <= (sink_tick % 24) >= 12;
		endcase
		sink_tick++;
	end

	// ------------------------------------------------------------------
	// Stimulus plumbing
	// ------------------------------------------------------------------

	// Drop valid if the last transfer left it high
	task automatic release_pixel();
		if (pixel_held) begin
			pixel_bus.valid <= 1'b0;
			pixel_held = 0;
		end
	endtask

	// Offer one pixel and hold it until the transfer; bursts with random gaps
	task automatic send_pixel(input bbrs_pkg::pixel_t px, input bit last);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				release_pixel();
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pixel_bus.valid     <= 1'b1;
		pixel_bus.red_in    <= px.red;
		pixel_bus.green_in  <= px.green;
		pixel_bus.blue_in   <= px.blue;
		pixel_bus.line_last <= last;
		pixel_held = 1;
		@(posedge clk);
		while (pixel_bus.ready !== 1'b1) @(posedge clk);
		box_average_pixel(px, last);
		pixels_sent++;
	endtask

	// Pause the sender until every predicted result has come back
	task automatic drain_results();
		release_pixel();
		while (blur_due.size() != 0) @(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	// Register write: setup then access; only done with the block idle
	task automatic cfg_write(input logic [bbrs_pkg::CFG_ADDR_W-1:0] addr,
		input logic [31:0] data);
		int unsigned v;
		drain_results();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if ((addr >> 2) == bbrs_pkg::REG_IDX_RADIUS) begin
			v = data[bbrs_pkg::RAD_W-1:0];
			radius_reg = (v > bbrs_pkg::MAX_RADIUS) ? bbrs_pkg::MAX_RADIUS : v;
		end
	endtask

	task automatic check_radius_readback();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_RADIUS;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		if (prdata !== 32'(radius_reg)) begin
			$error("prdata: expected %0d, got %0d", radius_reg, prdata);
			mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic bbrs_pkg::pixel_t line_pixel(int style, bbrs_pkg::pixel_t flat);
		bbrs_pkg::pixel_t px;
		case (style)
			0: px = flat;
			1: begin
				px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			default: px = bbrs_pkg::pixel_t'($urandom);
		endcase
		return px;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset radius of 1 must hold before any write
	task automatic test_reset_radius();
		check_radius_readback();
		send_pixel(bbrs_pkg::pixel_t'(24'hFFFFFF), 1'b0);
		send_pixel(bbrs_pkg::pixel_t'(24'h000000), 1'b0);
		send_pixel(bbrs_pkg::pixel_t'(24'hFF0080), 1'b1);
		lines_done++;
	endtask

	// A line of one pixel still flushes its single output
	task automatic test_lone_pixel();
		send_pixel(bbrs_pkg::pixel_t'(24'h123456), 1'b1);
		lines_done++;
	endtask

	// Fewer pixels than radius+1: the last pixel releases them all
	task automatic test_short_line();
		cfg_write(ADDR_RADIUS, 32'd4);
		check_radius_readback();
		send_pixel(bbrs_pkg::pixel_t'(24'hA5C30F), 1'b0);
		send_pixel(bbrs_pkg::pixel_t'(24'h5A3CF0), 1'b1);
		lines_done++;
	endtask

	// Radius 0 passes each pixel straight through
	task automatic test_zero_radius();
		cfg_write(ADDR_RADIUS, 32'd0);
		check_radius_readback();
		send_pixel(bbrs_pkg::pixel_t'(24'h01FE80), 1'b0);
		send_pixel(bbrs_pkg::pixel_t'(24'hFF0000), 1'b0);
		send_pixel(bbrs_pkg::pixel_t'(24'h00FF7F), 1'b1);
		lines_done++;
	endtask

	// Widest window with all-ones pixels: largest sums; upper data bits are ignored
	task automatic test_max_radius();
		cfg_write(ADDR_RADIUS, 32'hFFFF_FFFF);
		check_radius_readback();
		repeat (3) send_pixel(bbrs_pkg::pixel_t'(24'hFFFFFF), 1'b0);
		send_pixel(bbrs_pkg::pixel_t'(24'hFFFFFF), 1'b1);
		lines_done++;
	endtask

	// A write past the radius register must leave the radius alone
	task automatic test_spare_register();
		cfg_write(ADDR_SPARE, 32'd7);
		check_radius_readback();
		send_pixel(bbrs_pkg::pixel_t'(24'h808080), 1'b0);
		send_pixel(bbrs_pkg::pixel_t'(24'h7F7F7F), 1'b1);
		lines_done++;
	endtask

	// Radius written mid-line applies only from the next line on
	task automatic test_midline_radius();
		cfg_write(ADDR_RADIUS, 32'd2);
		send_pixel(bbrs_pkg::pixel_t'(24'h102030), 1'b0);
		send_pixel(bbrs_pkg::pixel_t'(24'hF0E0D0), 1'b0);
		send_pixel(bbrs_pkg::pixel_t'(24'h405060), 1'b0);
		cfg_write(ADDR_RADIUS, 32'd5);
		check_radius_readback();
		send_pixel(bbrs_pkg::pixel_t'(24'h0000FF), 1'b0);
		send_pixel(bbrs_pkg::pixel_t'(24'h00FF00), 1'b0);
		send_pixel(bbrs_pkg::pixel_t'(24'hFF0000), 1'b1);
		send_pixel(bbrs_pkg::pixel_t'(24'h333333), 1'b0);
		send_pixel(bbrs_pkg::pixel_t'(24'hCCCCCC), 1'b0);
		send_pixel(bbrs_pkg::pixel_t'(24'h999999), 1'b1);
		lines_done += 2;
	endtask

	// Random lines over several radius settings, including both extremes
	task automatic test_random_lines();
		int unsigned      r;
		int               items_left;
		int               len;
		int               kind;
		int               style;
		bit               cut;
		bit               force_long;
		bbrs_pkg::pixel_t flat;
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: r = 0;
				1: r = bbrs_pkg::MAX_RADIUS;
				2: r = $urandom_range(1, 3);
				default: r = ($urandom_range(0, 3) == 0)
					? $urandom_range(7, bbrs_pkg::MAX_RADIUS) : $urandom_range(1, 6);
			endcase
			// Junk in the upper data bits; only the low radius bits count
			cfg_write(ADDR_RADIUS, ($urandom & 32'hFFFF_FFE0) | 32'(r));
			check_radius_readback();
			items_left = PHASE_ITEMS;
			// Run one line past the position counter's saturation point
			force_long = (phase == 2);
			while (items_left > 0) begin
				kind = $urandom_range(0, 9);
				if (force_long) len = $urandom_range(bbrs_pkg::WIN_DEPTH,
					bbrs_pkg::WIN_DEPTH + 26);
				else if (kind < 2) len = $urandom_range(1, r + 1);
				else if (kind < 9) len = $urandom_range(r + 1, 2 * r + 6);
				else len = $urandom_range(2 * r + 2, 70);
				cut = 0;
				// Sometimes stop mid-line so the next radius write lands inside a line
				if (!force_long && len >= items_left && $urandom_range(0, 2) == 0) begin
					len = items_left;
					cut = 1;
				end
				force_long = 0;
				style = $urandom_range(0, 5);
				flat  = bbrs_pkg::pixel_t'($urandom);
				for (int k = 0; k < len; k++) begin
					send_pixel(line_pixel(style, flat), (k == len - 1) && !cut);
				end
				if (!cut) lines_done++;
				if (len > longest_line) longest_line = len;
				items_left -= len;
				if ($urandom_range(0, 29) == 0) drain_results();
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		// Model reset state
		foreach (pix_hist[i]) pix_hist[i] = '0;
		foreach (chan_sum[i]) chan_sum[i] = 0;
		line_head    = '0;
		line_pos     = 0;
		line_radius  = 0;
		radius_reg   = bbrs_pkg::RADIUS_RST;
		mismatches   = 0;
		pixels_sent  = 0;
		results_seen = 0;
		lines_done   = 0;
		longest_line = 0;
		radius_seen  = '0;
		burst_left   = 0;
		pixel_held   = 0;

		arst_n              <= 1'b0;
		psel                <= 1'b0;
		penable             <= 1'b0;
		pwrite              <= 1'b0;
		paddr               <= '0;
		pwdata              <= '0;
		pixel_bus.valid     <= 1'b0;
		pixel_bus.red_in    <= '0;
		pixel_bus.green_in  <= '0;
		pixel_bus.blue_in   <= '0;
		pixel_bus.line_last <= 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_radius();
		test_lone_pixel();
		test_short_line();
		test_zero_radius();
		test_max_radius();
		test_spare_register();
		test_midline_radius();
		test_random_lines();

		// Let the tail of the last line flush out before judging
		drain_results();

		$display("blur run: %0d pixels in %0d complete lines (longest %0d), %0d results checked",
			pixels_sent, lines_done, longest_line, results_seen);
		$display("radius values latched at line start (bit mask): %h, mismatches: %0d",
			radius_seen, mismatches);
		if (mismatches == 0) begin
			$display("box_blur_running_sum_tb: PASS");
		end else begin
			$display("box_blur_running_sum_tb: FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/bbrs_pkg.sv
rtl/core/bbrs_pixel_if.sv
rtl/core/bbrs_blur_if.sv
rtl/core/bbrs_cfg.sv
rtl/core/bbrs_front.sv
rtl/core/bbrs_fifo.sv
rtl/core/bbrs_back.sv
rtl/core/box_blur_running_sum.sv
verif/box_blur_running_sum_tb.sv
